@@ rtl/rpa_pkg.sv @@
// Shared types, constants and widths for the dual encoder rpm averager.
package rpa_pkg;

  localparam int ACT_W  = 2;
  localparam int TIME_W = 32;
  localparam int CPR_W  = 8;
  localparam int RPM_W  = 16;
  localparam int CNT_W  = 16;

  localparam int WINDOW_DEF = 10;

  localparam logic [CPR_W-1:0] CPR_RESET = 8'd22;
  localparam logic [25:0] USEC_PER_MINUTE = 26'd60000000;
  localparam logic [RPM_W-1:0] RPM_MAX = 16'hFFFF;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // clicks * 60e6, cpr * dt, rounded numerator and doubled denominator
  localparam int MUL_W  = CNT_W + 26;
  localparam int PROD_W = CPR_W + TIME_W;
  localparam int NUM_W  = MUL_W + 2;
  localparam int DEN_W  = PROD_W + 1;
  localparam int STEP_W = $clog2(NUM_W + 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_STB_CLICK = 2'd0,
    ACT_PRT_CLICK = 2'd1,
    ACT_SAMPLE    = 2'd2,
    ACT_REPORT    = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_RDIV,
    ST_WRITE,
    ST_SUM,
    ST_AVG,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [RPM_W-1:0] stb;
    logic [RPM_W-1:0] prt;
  } ring_ent_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/rpa_ifs.sv @@
// Valid/ready channel interfaces for input words, result words and configuration.
interface rpa_in_if import rpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [TIME_W-1:0] time_us;

  modport source (output valid, output action, output time_us, input ready);
  modport sink   (input valid, input action, input time_us, output ready);
endinterface

interface rpa_out_if import rpa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RPM_W-1:0] starboard_avg_rpm;
  logic [RPM_W-1:0] port_avg_rpm;

  modport source (output valid, output starboard_avg_rpm, output port_avg_rpm, input ready);
  modport sink   (input valid, input starboard_avg_rpm, input port_avg_rpm, output ready);
endinterface

interface rpa_cfg_if import rpa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CPR_W-1:0] clicks_per_rev;

  modport source (output valid, output clicks_per_rev, input ready);
  modport sink   (input valid, input clicks_per_rev, output ready);
endinterface

@@ rtl/rpa_cell.sv @@
// One ring cell: holds a starboard and a port rpm entry, loads from its neighbor on shift.
module rpa_cell import rpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      shift,
  input  ring_ent_t d,
  output ring_ent_t q
);

  ring_ent_t ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else if (shift) begin
      ent_r <= d;
    end
  end

  assign q = ent_r;

endmodule

@@ rtl/rpa_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
module rpa_div import rpa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output div_stat_t        stat
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [NUM_W-1:0]  quo_r;
  logic [DEN_W:0]    trial;
  logic              fits;

  // shift in the next numerator bit and try the subtract
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

@@ rtl/dual_encoder_rpm_averager.sv @@
// Top level: click counters, rpm computation, ring of averaging cells, report output.
//
//  channel  | dir | words                               | ready
//  ---------+-----+-------------------------------------+---------------------------
//  in_ch    | in  | action, time_us                     | high while idle
//  out_ch   | out | starboard_avg_rpm, port_avg_rpm     | output register, held
//  cfg_ch   | in  | clicks_per_rev                      | always high
//
//  Clicks and timer wrap samples leave the input ready. Any other sample holds the input
//  off until both serial dividers are done, at one quotient bit per cycle. A report
//  holds it off for one ring rotation through the cells, one reciprocal multiply by
//  1/WINDOW and one load of the output register.
//  Synchronous active-low reset clears counters, prev time and every ring cell.
//  A pending result in the output register stalls only the end of the next report.
module dual_encoder_rpm_averager import rpa_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rpa_in_if.sink    in_ch,
  rpa_out_if.source out_ch,
  rpa_cfg_if.sink   cfg_ch
);

  localparam int SUM_W  = RPM_W + $clog2(WINDOW);
  localparam int RC_W   = $clog2(WINDOW + 1);
  // floor(sum / WINDOW) = (sum * ceil(2^AVG_SH / WINDOW)) >> AVG_SH for any SUM_W-bit sum
  localparam int AVG_SH = SUM_W + $clog2(WINDOW);
  localparam int RCP_W  = SUM_W + 1;
  localparam int AVP_W  = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] AVG_RCP =
    RCP_W'(((64'd1 << AVG_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  state_t state_r;
  state_t state_nxt;

  logic [CPR_W-1:0]  cpr_r;
  logic [CNT_W-1:0]  stb_cnt_r;
  logic [CNT_W-1:0]  prt_cnt_r;
  logic [TIME_W-1:0] prev_time_r;
  logic [CNT_W-1:0]  sc_r;
  logic [CNT_W-1:0]  pc_r;
  logic [TIME_W-1:0] dt_r;
  logic [MUL_W-1:0]  prod_s_r;
  logic [MUL_W-1:0]  prod_p_r;
  logic [PROD_W-1:0] den_r;
  logic              zero_r;
  logic [SUM_W-1:0]  acc_s_r;
  logic [SUM_W-1:0]  acc_p_r;
  logic [RC_W-1:0]   rot_cnt_r;
  logic [RPM_W-1:0]  avg_s_r;
  logic [RPM_W-1:0]  avg_p_r;

  logic             out_valid_r;
  logic [RPM_W-1:0] out_stb_r;
  logic [RPM_W-1:0] out_prt_r;

  logic in_acc;
  logic in_ready;
  logic ring_shift;
  logic ring_new;
  logic div_start;
  logic out_load;
  logic div_done;
  logic wrap;

  logic [NUM_W-1:0] num_s;
  logic [NUM_W-1:0] num_p;
  logic [DEN_W-1:0] den2;
  logic [NUM_W-1:0] q_s;
  logic [NUM_W-1:0] q_p;
  div_stat_t        st_s;
  div_stat_t        st_p;
  logic [AVP_W-1:0] avp_s;
  logic [AVP_W-1:0] avp_p;

  ring_ent_t new_ent;
  ring_ent_t ring_d [WINDOW];
  ring_ent_t ring_q [WINDOW];

  function automatic logic [RPM_W-1:0] sat_rpm(input logic [NUM_W-1:0] q, input logic z);
    logic [RPM_W-1:0] r;
    if (z) begin
      r = '0;
    end else if (|q[NUM_W-1:RPM_W]) begin
      r = RPM_MAX;
    end else begin
      r = q[RPM_W-1:0];
    end
    return r;
  endfunction

  assign in_acc   = in_ch.valid && in_ready;
  assign wrap     = in_ch.time_us < prev_time_r;
  assign div_done = st_s.done && st_p.done;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (action_t'(in_ch.action))
            ACT_SAMPLE:    state_nxt = wrap ? ST_IDLE : ST_MUL;
            ACT_REPORT:    state_nxt = ST_SUM;
            ACT_STB_CLICK: state_nxt = ST_IDLE;
            ACT_PRT_CLICK: state_nxt = ST_IDLE;
            default:       state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MUL:    state_nxt = ST_ADD;
      ST_ADD:    state_nxt = ST_RDIV;
      ST_RDIV:   state_nxt = div_done ? ST_WRITE : ST_RDIV;
      ST_WRITE:  state_nxt = ST_IDLE;
      ST_SUM:    state_nxt = (rot_cnt_r == '0) ? ST_AVG : ST_SUM;
      ST_AVG:    state_nxt = ST_OUT;
      ST_OUT:    state_nxt = (!out_valid_r || out_ch.ready) ? ST_IDLE : ST_OUT;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready   = 1'b0;
    ring_shift = 1'b0;
    ring_new   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_ADD:    div_start = 1'b1;
      ST_WRITE: begin
        ring_shift = 1'b1;
        ring_new   = 1'b1;
      end
      ST_SUM:    ring_shift = 1'b1;
      ST_OUT:    out_load = !out_valid_r || out_ch.ready;
      default:   in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r <= CPR_RESET;
    end else if (cfg_ch.valid) begin
      cpr_r <= cfg_ch.clicks_per_rev;
    end
  end
  assign cfg_ch.ready = 1'b1;

  // click counters and sample capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stb_cnt_r   <= '0;
      prt_cnt_r   <= '0;
      prev_time_r <= '0;
    end else if (in_acc) begin
      case (action_t'(in_ch.action))
        ACT_STB_CLICK: begin
          if (stb_cnt_r != COUNT_MAX) stb_cnt_r <= stb_cnt_r + 1'b1;
        end
        ACT_PRT_CLICK: begin
          if (prt_cnt_r != COUNT_MAX) prt_cnt_r <= prt_cnt_r + 1'b1;
        end
        ACT_SAMPLE: begin
          stb_cnt_r   <= '0;
          prt_cnt_r   <= '0;
          prev_time_r <= in_ch.time_us;
        end
        default: begin
          prev_time_r <= prev_time_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sc_r <= stb_cnt_r;
      pc_r <= prt_cnt_r;
      dt_r <= in_ch.time_us - prev_time_r;
    end
    if (state_r == ST_MUL) begin
      prod_s_r <= MUL_W'(sc_r) * MUL_W'(USEC_PER_MINUTE);
      prod_p_r <= MUL_W'(pc_r) * MUL_W'(USEC_PER_MINUTE);
      den_r    <= PROD_W'(cpr_r) * PROD_W'(dt_r);
    end
    if (state_r == ST_ADD) begin
      zero_r <= den_r == '0;
    end
  end

  // round half up: (2*num + den) / (2*den)
  assign num_s = NUM_W'({prod_s_r, 1'b0}) + NUM_W'(den_r);
  assign num_p = NUM_W'({prod_p_r, 1'b0}) + NUM_W'(den_r);
  assign den2  = {den_r, 1'b0};

  rpa_div u_div_stb (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_s),
    .den   (den2),
    .quo   (q_s),
    .stat  (st_s)
  );

  rpa_div u_div_prt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_p),
    .den   (den2),
    .quo   (q_p),
    .stat  (st_p)
  );

  // the oldest entry drops off the far end when a new one enters
  assign new_ent.stb = sat_rpm(q_s, zero_r);
  assign new_ent.prt = sat_rpm(q_p, zero_r);

  assign ring_d[0] = ring_new ? new_ent : ring_q[WINDOW-1];

  for (genvar i = 0; i < WINDOW; i++) begin : g_ring
    if (i > 0) begin : g_link
      assign ring_d[i] = ring_q[i-1];
    end
    rpa_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (ring_shift),
      .d     (ring_d[i]),
      .q     (ring_q[i])
    );
  end

  // one full rotation sums every entry and leaves the ring as it was
  always_ff @(posedge clk) begin
    if (in_acc) begin
      acc_s_r   <= '0;
      acc_p_r   <= '0;
      rot_cnt_r <= RC_W'(WINDOW - 1);
    end else if (state_r == ST_SUM) begin
      acc_s_r   <= acc_s_r + SUM_W'(ring_q[WINDOW-1].stb);
      acc_p_r   <= acc_p_r + SUM_W'(ring_q[WINDOW-1].prt);
      rot_cnt_r <= rot_cnt_r - 1'b1;
    end
  end

  assign avp_s = AVP_W'(acc_s_r) * AVP_W'(AVG_RCP);
  assign avp_p = AVP_W'(acc_p_r) * AVP_W'(AVG_RCP);

  always_ff @(posedge clk) begin
    if (state_r == ST_AVG) begin
      avg_s_r <= avp_s[AVG_SH +: RPM_W];
      avg_p_r <= avp_p[AVG_SH +: RPM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_stb_r <= avg_s_r;
      out_prt_r <= avg_p_r;
    end
  end

  assign in_ch.ready              = in_ready;
  assign out_ch.valid             = out_valid_r;
  assign out_ch.starboard_avg_rpm = out_stb_r;
  assign out_ch.port_avg_rpm      = out_prt_r;

`ifndef SYNTHESIS
  a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (!st_s.busy && !st_p.busy))
    else $error("divider started while busy");

  a_div_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    st_s.done == st_p.done)
    else $error("divider lanes out of step");

  a_sum_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM && rot_cnt_r == '0) |=> state_r == ST_AVG)
    else $error("ring rotation did not end after one pass");

  a_avg_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && $past(state_r == ST_OUT)) |-> ($stable(avg_s_r) && $stable(avg_p_r)))
    else $error("average changed while waiting for output");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("report word lost at output register");
`endif

endmodule

@@ sim/tb_dual_encoder_rpm_averager.sv @@
// Self-checking testbench for the dual encoder rpm averager: directed cases, then random traffic.
`timescale 1ns / 100ps

module tb_dual_encoder_rpm_averager;
  import rpa_pkg::*;

  localparam int WIN           = WINDOW_DEF;
  localparam int SETTLE_CYCLES = 80;    // longer than a report or a sample
  localparam int STUCK_LIMIT   = 4000;  // cycles without any handshake
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [RPM_W-1:0] stb;
    logic [RPM_W-1:0] prt;
  } avg_pair_t;

  logic clk;
  logic rst_n;

  rpa_in_if  in_ch();
  rpa_out_if out_ch();
  rpa_cfg_if cfg_ch();

  dual_encoder_rpm_averager uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Tachometer state as the block should hold it
  logic [CPR_W-1:0]  cpr_now;
  logic [CNT_W-1:0]  stb_clicks;
  logic [CNT_W-1:0]  prt_clicks;
  logic [TIME_W-1:0] last_sample_us;
  logic [RPM_W-1:0]  stb_rpm_ring [WIN];
  logic [RPM_W-1:0]  prt_rpm_ring [WIN];
  int                ring_slot;

  avg_pair_t avg_expect_q [$];

  bit tx_idle;
  bit rx_idle;
  int rx_hold_req;
  int words_sent;
  int reports_checked;
  int fail_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void flag_error(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endfunction

  function automatic logic [RPM_W-1:0] tach_rpm(logic [CNT_W-1:0] clicks,
                                                logic [TIME_W-1:0] dt,
                                                logic [CPR_W-1:0] cpr);
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] q;
    if (dt == '0 || cpr == '0) return '0;
    den = 64'(cpr) * 64'(dt);
    num = 64'(clicks) * 64'(USEC_PER_MINUTE);
    // round half up
    q = (2 * num + den) / (2 * den);
    return (q > 64'(RPM_MAX)) ? RPM_MAX : q[RPM_W-1:0];
  endfunction

  function automatic void tach_reset();
    cpr_now        = CPR_RESET;
    stb_clicks     = '0;
    prt_clicks     = '0;
    last_sample_us = '0;
    ring_slot      = 0;
    for (int i = 0; i < WIN; i++) begin
      stb_rpm_ring[i] = '0;
      prt_rpm_ring[i] = '0;
    end
  endfunction

  function automatic void tach_apply(action_t act, logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] dt;
    logic [31:0]       sum_s;
    logic [31:0]       sum_p;
    avg_pair_t         res;
    case (act)
      ACT_STB_CLICK: begin
        if (stb_clicks != COUNT_MAX) stb_clicks++;
      end
      ACT_PRT_CLICK: begin
        if (prt_clicks != COUNT_MAX) prt_clicks++;
      end
      ACT_SAMPLE: begin
        dt = t - last_sample_us;
        // timer wrap: restart timing, leave the rings alone
        if (t >= last_sample_us) begin
          stb_rpm_ring[ring_slot] = tach_rpm(stb_clicks, dt, cpr_now);
          prt_rpm_ring[ring_slot] = tach_rpm(prt_clicks, dt, cpr_now);
          ring_slot = (ring_slot == WIN - 1) ? 0 : ring_slot + 1;
        end
        last_sample_us = t;
        stb_clicks     = '0;
        prt_clicks     = '0;
      end
      default: begin
        sum_s = '0;
        sum_p = '0;
        for (int i = 0; i < WIN; i++) begin
          sum_s += 32'(stb_rpm_ring[i]);
          sum_p += 32'(prt_rpm_ring[i]);
        end
        res.stb = RPM_W'(sum_s / WIN);
        res.prt = RPM_W'(sum_p / WIN);
        avg_expect_q.push_back(res);
      end
    endcase
  endfunction

  // Valid stays high on return; the next call or settle_block decides what follows.
  task automatic send_word(action_t act, logic [TIME_W-1:0] t);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.time_us <= t;
    do @(posedge clk); while (!in_ch.ready);
    tach_apply(act, t);
    words_sent++;
  endtask

  task automatic send_clicks(action_t act, int n);
    repeat (n) send_word(act, $urandom);
  endtask

  // Drop valid, drain pending reports, then give a sample time to finish.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (avg_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cpr(logic [CPR_W-1:0] value);
    settle_block();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.clicks_per_rev <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cpr_now = value;
  endtask

  task automatic test_special_cases();
    send_word(ACT_REPORT, $urandom);          // rings still empty
    send_word(ACT_SAMPLE, 32'd0);             // zero interval from reset
    send_word(ACT_STB_CLICK, 32'hFFFF_FFFF);
    send_word(ACT_STB_CLICK, 32'd0);
    send_word(ACT_PRT_CLICK, $urandom);
    send_word(ACT_STB_CLICK, $urandom);
    send_word(ACT_SAMPLE, 32'd10000);
    send_word(ACT_STB_CLICK, $urandom);
    send_word(ACT_SAMPLE, 32'd10000);         // zero interval with a click pending
    send_clicks(ACT_STB_CLICK, 3);
    send_clicks(ACT_PRT_CLICK, 2);
    send_word(ACT_SAMPLE, 32'd10001);         // one microsecond: rpm saturates
    send_word(ACT_STB_CLICK, $urandom);
    send_word(ACT_PRT_CLICK, $urandom);
    send_word(ACT_SAMPLE, 32'd5);             // timer wrap
    send_word(ACT_PRT_CLICK, $urandom);
    send_word(ACT_SAMPLE, 32'hFFFF_FFFF);     // near-maximum interval
    send_word(ACT_REPORT, $urandom);
  endtask

  task automatic test_zero_cpr();
    write_cpr('0);
    send_word(ACT_SAMPLE, 32'd0);
    send_clicks(ACT_STB_CLICK, 2);
    send_clicks(ACT_PRT_CLICK, 1);
    send_word(ACT_SAMPLE, 32'd5000);
    send_word(ACT_REPORT, $urandom);
  endtask

  task automatic test_click_burst();
    write_cpr(8'd1);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_word(ACT_SAMPLE, 32'd0);
    send_clicks(ACT_STB_CLICK, 60);
    send_clicks(ACT_PRT_CLICK, 3);
    send_word(ACT_SAMPLE, 32'h1000_0000);
    send_word(ACT_REPORT, $urandom);
  endtask

  task automatic test_output_stall();
    settle_block();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    // keep offering reports so the output register and the block fill up
    repeat (6) send_word(ACT_REPORT, $urandom);
    send_clicks(ACT_STB_CLICK, 4);
    send_word(ACT_SAMPLE, last_sample_us + 32'd20000);
    send_word(ACT_REPORT, $urandom);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic run_traffic(int n_words);
    int start;
    int pick;
    logic [TIME_W-1:0] t;
    start = words_sent;
    while (words_sent - start < n_words) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_idle = $urandom_range(0, 1);
        rx_idle = $urandom_range(0, 1);
      end
      if ($urandom_range(0, 9) == 0) begin
        // noise: anything at all
        repeat ($urandom_range(1, 3)) send_word(action_t'($urandom_range(0, 3)), $urandom);
      end else begin
        repeat ($urandom_range(0, 15))
          send_word(action_t'($urandom_range(0, 1)), $urandom);
        pick = $urandom_range(0, 15);
        case (pick)
          0:       t = last_sample_us;
          1:       t = $urandom;
          2:       t = last_sample_us + $urandom_range(1, 50);
          3:       t = last_sample_us + $urandom;
          default: t = last_sample_us + $urandom_range(500, 200000);
        endcase
        send_word(ACT_SAMPLE, t);
        if ($urandom_range(0, 4) < 2) send_word(ACT_REPORT, $urandom);
      end
    end
  endtask

  // Result receiver: random or long holds on ready
  initial begin : rx_side
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold_req) @(posedge clk);
        rx_hold_req = 0;
      end
      gap = rx_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid && rx_hold_req == 0);
    end
  end

  always @(posedge clk) begin : avg_check
    avg_pair_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (avg_expect_q.size() == 0) begin
        flag_error($sformatf("unexpected result word stb=%0d prt=%0d",
                             out_ch.starboard_avg_rpm, out_ch.port_avg_rpm));
      end else begin
        want = avg_expect_q.pop_front();
        reports_checked++;
        if (out_ch.starboard_avg_rpm !== want.stb)
          flag_error($sformatf("starboard avg: expected %0d, got %0d",
                               want.stb, out_ch.starboard_avg_rpm));
        if (out_ch.port_avg_rpm !== want.prt)
          flag_error($sformatf("port avg: expected %0d, got %0d",
                               want.prt, out_ch.port_avg_rpm));
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("[%0t] no handshake for %0d cycles", $realtime, STUCK_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : main
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.action          <= ACT_STB_CLICK;
    in_ch.time_us         <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.clicks_per_rev <= CPR_RESET;
    tx_idle         = 1'b1;
    rx_idle         = 1'b1;
    rx_hold_req     = 0;
    words_sent      = 0;
    reports_checked = 0;
    fail_count      = 0;
    tach_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_cases();
    test_zero_cpr();
    test_click_burst();
    test_output_stall();
    write_cpr(8'd1);
    run_traffic(200);
    write_cpr(8'd255);
    run_traffic(200);
    write_cpr(CPR_W'($urandom_range(2, 254)));
    run_traffic(200);
    write_cpr(CPR_RESET);
    run_traffic(200);

    settle_block();
    $display("Covered %0d input words and %0d averaged reports", words_sent, reports_checked);
    $display("clicks_per_rev 22/0/1/255/random, timer wrap, rpm saturation, long output stall");
    if (fail_count == 0 && avg_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d errors, %0d reports missing", fail_count, avg_expect_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ dual_encoder_rpm_averager.f @@
rtl/rpa_pkg.sv
rtl/rpa_ifs.sv
rtl/rpa_cell.sv
rtl/rpa_div.sv
rtl/dual_encoder_rpm_averager.sv
sim/tb_dual_encoder_rpm_averager.sv
